>>> rtl/core/lhpt_pkg.sv
// Shared types and constants of the level-hashed page table.
package lhpt_pkg;

  localparam int KEY_W = 20;
  localparam int VAL_W = 32;
  localparam int ENTRY_W = 1 + KEY_W + VAL_W;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input item, start hashing
    logic hash_occ;  // hash the captured occupant address
    logic wr;        // write a slot
    logic wr_clear;  // write an empty slot
    logic wr_occ;    // write the occupant at the current address
    logic bottom;    // level of the access
    logic use_occ;   // use occupant buckets
    logic second;    // second bucket of the pair
    logic cap_occ;   // capture the read slot as the occupant
    logic cap_pos;   // remember this slot position as the target
    logic clr;       // clearing pass write
    logic hold;      // result register load
    logic res_ok;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;
    logic rd_valid;
    logic rd_match;
    logic mode;
  } stat_t;

endpackage

>>> rtl/core/lhpt_ram.sv
// Generic single-port RAM with registered read.
module lhpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One access per cycle; the read data is registered.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> rtl/core/lhpt_datapath.sv
// Datapath: hashing unit, bucket registers, slot addressing and the two tables.
module lhpt_datapath #(
  parameter int TABLE_BUCKETS = 256,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  lhpt_pkg::cmd_t                 cmd,
  input  logic [$clog2(SLOTS_PER_BUCKET > 1 ? SLOTS_PER_BUCKET : 2)-1:0] slot,
  input  logic [$clog2(TABLE_BUCKETS)-1:0] clr_bucket,
  input  logic                           in_mode,
  input  logic [31:0]                    in_addr,
  input  logic [lhpt_pkg::KEY_W-1:0]     in_key,
  input  logic [lhpt_pkg::VAL_W-1:0]     in_value,
  input  logic [31:0]                    offset,
  output lhpt_pkg::stat_t                stat,
  output logic                           res_ok,
  output logic                           res_level,
  output logic [7:0]                     res_bucket,
  output logic [31:0]                    res_value
);

  localparam int HALF = TABLE_BUCKETS / 2;
  localparam int MOD = HALF - 1;
  localparam int BW = $clog2(TABLE_BUCKETS);
  localparam int SW = $clog2(SLOTS_PER_BUCKET > 1 ? SLOTS_PER_BUCKET : 2);
  localparam int SLW = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 0;
  localparam int TAW = BW + SLW;
  localparam int BAW = BW - 1 + SLW;
  localparam int FK = $clog2(HALF);
  localparam logic [31:0] MOD_W = 32'(MOD);
  localparam logic [31:0] FOLD_C = 32'((1 << FK) - MOD);

  // Captured item.
  logic                       mode;
  logic [31:0]                addr;
  logic [lhpt_pkg::KEY_W-1:0] key;
  logic [lhpt_pkg::VAL_W-1:0] value;
  logic [lhpt_pkg::KEY_W-1:0] occ_key;
  logic [lhpt_pkg::VAL_W-1:0] occ_value;
  logic [BW-1:0]              h1, h2, o1, o2;
  logic [BW-1:0]              pos_bucket;
  logic [SW-1:0]              pos_slot;
  logic                       pos_bottom;

  // Hash unit signals.
  logic [31:0] occ_addr, hash_src;
  logic [31:0] fold_a, fold_b, fold_a_next, fold_b_next;
  logic [31:0] hash_a, hash_b;
  logic        hash_busy, hash_occ_sel, fold_done;

  // Addressing and table signals.
  logic [BW-1:0]                cur_bucket, lvl_bucket, acc_bucket, res_b;
  logic [SW-1:0]                acc_slot;
  logic                         acc_bottom;
  logic [TAW-1:0]               top_addr;
  logic [BAW-1:0]               bot_addr;
  logic [lhpt_pkg::ENTRY_W-1:0] wdata, top_rd, bot_rd, rd;
  logic                         top_we, bot_we, rd_bottom;

  // Modulo by HALF-1: 2^FK leaves FOLD_C, so the high part is folded onto the
  // low part one step per cycle until it is gone, then one subtract finishes.
  assign occ_addr    = occ_value + offset;
  assign hash_src    = cmd.load ? in_addr : occ_addr;
  assign fold_a_next = 32'(fold_a[FK-1:0]) + 32'((fold_a >> FK) * FOLD_C);
  assign fold_b_next = 32'(fold_b[FK-1:0]) + 32'((fold_b >> FK) * FOLD_C);
  assign fold_done   = ((fold_a >> FK) == 32'd0) && ((fold_b >> FK) == 32'd0);
  assign hash_a      = (fold_a >= MOD_W) ? fold_a - MOD_W : fold_a;
  assign hash_b      = (fold_b >= MOD_W) ? fold_b - MOD_W : fold_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      hash_busy <= 1'b0;
    end else if (cmd.load || cmd.hash_occ) begin
      hash_busy <= 1'b1;
    end else if (hash_busy && fold_done) begin
      hash_busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.hash_occ) begin
      fold_a       <= hash_src;
      fold_b       <= {hash_src[28:0], 3'b000} - hash_src;
      hash_occ_sel <= cmd.hash_occ;
    end else if (hash_busy) begin
      if (fold_done) begin
        if (hash_occ_sel) begin
          o1 <= BW'(hash_a);
          o2 <= BW'(hash_b) + BW'(HALF);
        end else begin
          h1 <= BW'(hash_a);
          h2 <= BW'(hash_b) + BW'(HALF);
        end
      end else begin
        fold_a <= fold_a_next;
        fold_b <= fold_b_next;
      end
    end
  end

  // Item capture.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode  <= in_mode;
      addr  <= in_addr;
      key   <= in_key;
      value <= in_value;
    end
  end

  // Slot address generation.
  assign cur_bucket = cmd.use_occ ? (cmd.second ? o2 : o1) : (cmd.second ? h2 : h1);
  assign lvl_bucket = cmd.bottom ? (cur_bucket >> 1) : cur_bucket;

  always_comb begin
    if (cmd.clr) begin
      acc_bucket = clr_bucket;
      acc_slot   = slot;
      acc_bottom = 1'b0;
    end else if (cmd.wr && !cmd.wr_occ) begin
      acc_bucket = pos_bucket;
      acc_slot   = pos_slot;
      acc_bottom = pos_bottom;
    end else begin
      acc_bucket = lvl_bucket;
      acc_slot   = slot;
      acc_bottom = cmd.bottom;
    end
  end

  if (SLW > 0) begin : g_multi
    assign top_addr = TAW'({acc_bucket, acc_slot[SLW-1:0]});
    assign bot_addr = BAW'({acc_bucket[BW-2:0], acc_slot[SLW-1:0]});
  end else begin : g_single
    logic unused_slot;
    assign unused_slot = acc_slot[0];
    assign top_addr = TAW'(acc_bucket);
    assign bot_addr = BAW'(acc_bucket[BW-2:0]);
  end

  always_comb begin
    if (cmd.clr || cmd.wr_clear) begin
      wdata = '0;
    end else if (cmd.wr_occ) begin
      wdata = {1'b1, occ_key, occ_value};
    end else begin
      wdata = {1'b1, key, value};
    end
  end

  assign top_we = (cmd.wr || cmd.clr) && !acc_bottom;
  assign bot_we = (cmd.wr && acc_bottom) || (cmd.clr && !acc_bucket[BW-1]);

  lhpt_ram #(.WIDTH(lhpt_pkg::ENTRY_W), .DEPTH(1 << TAW)) u_top (
    .clk(clk), .we(top_we), .addr(top_addr), .wdata(wdata), .rdata(top_rd)
  );
  lhpt_ram #(.WIDTH(lhpt_pkg::ENTRY_W), .DEPTH(1 << BAW)) u_bot (
    .clk(clk), .we(bot_we), .addr(bot_addr), .wdata(wdata), .rdata(bot_rd)
  );

  always_ff @(posedge clk) begin
    rd_bottom <= cmd.bottom;
  end
  assign rd = rd_bottom ? bot_rd : top_rd;

  // Target position and occupant capture.
  always_ff @(posedge clk) begin
    if (cmd.cap_pos) begin
      pos_bucket <= lvl_bucket;
      pos_slot   <= slot;
      pos_bottom <= cmd.bottom;
    end
    if (cmd.cap_occ) begin
      occ_key   <= rd[lhpt_pkg::VAL_W +: lhpt_pkg::KEY_W];
      occ_value <= rd[lhpt_pkg::VAL_W-1:0];
    end
  end

  assign stat.hash_done = !hash_busy && !cmd.load && !cmd.hash_occ;
  assign stat.rd_valid  = rd[lhpt_pkg::ENTRY_W-1];
  assign stat.rd_match  = rd[lhpt_pkg::VAL_W +: lhpt_pkg::KEY_W] == key;
  assign stat.mode      = mode;

  // Result register; the target position names the bucket and level.
  assign res_b = pos_bucket;
  always_ff @(posedge clk) begin
    if (cmd.hold) begin
      res_ok     <= cmd.res_ok;
      res_level  <= cmd.res_ok && pos_bottom;
      res_bucket <= cmd.res_ok ? 8'(res_b) : 8'd0;
      res_value  <= !cmd.res_ok ? 32'd0
                  : (mode == lhpt_pkg::MODE_DELETE ? addr - offset : value);
    end
  end

endmodule

>>> rtl/core/lhpt_ctrl.sv
// Controller: sequences clearing, search, eviction, delete and result handoff.
module lhpt_ctrl #(
  parameter int TABLE_BUCKETS = 256,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  output logic                           out_valid,
  input  logic                           out_stall,
  input  lhpt_pkg::stat_t                stat,
  output lhpt_pkg::cmd_t                 cmd,
  output logic [$clog2(SLOTS_PER_BUCKET > 1 ? SLOTS_PER_BUCKET : 2)-1:0] slot,
  output logic [$clog2(TABLE_BUCKETS)-1:0] clr_bucket
);

  localparam int BW = $clog2(TABLE_BUCKETS);
  localparam int SW = $clog2(SLOTS_PER_BUCKET > 1 ? SLOTS_PER_BUCKET : 2);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS_PER_BUCKET - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_HASH   = 4'd2;
  localparam logic [3:0] S_FREE   = 4'd3;  // read slot for free search
  localparam logic [3:0] S_FREEC  = 4'd4;  // check it
  localparam logic [3:0] S_EVR    = 4'd5;  // read candidate occupant
  localparam logic [3:0] S_EVC    = 4'd6;
  localparam logic [3:0] S_OHASH  = 4'd7;
  localparam logic [3:0] S_OR     = 4'd8;  // read occupant's buckets
  localparam logic [3:0] S_OC     = 4'd9;
  localparam logic [3:0] S_OMOVE  = 4'd10;
  localparam logic [3:0] S_DELR   = 4'd11;
  localparam logic [3:0] S_DELC   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]    state, state_next;
  logic [SW-1:0] cslot, cslot_next;
  logic          second, second_next;
  logic          bottom, bottom_next;
  logic [1:0]    dsel, dsel_next;
  logic [SW-1:0] oslot, oslot_next;
  logic          osecond, osecond_next;
  logic          ok, ok_next;
  logic [BW-1:0] clr_bucket_next;
  logic          cand_last, occ_last;

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      cslot      <= '0;
      second     <= 1'b0;
      bottom     <= 1'b0;
      dsel       <= '0;
      oslot      <= '0;
      osecond    <= 1'b0;
      ok         <= 1'b0;
      clr_bucket <= '0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      cslot      <= cslot_next;
      second     <= second_next;
      bottom     <= bottom_next;
      dsel       <= dsel_next;
      oslot      <= oslot_next;
      osecond    <= osecond_next;
      ok         <= ok_next;
      clr_bucket <= clr_bucket_next;
      if (cmd.hold) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_stall  = state != S_IDLE;
  assign slot      = cmd.use_occ ? oslot : cslot;
  assign cand_last = second && cslot == LAST_SLOT;
  assign occ_last  = osecond && oslot == LAST_SLOT;

  // Next state and commands.
  always_comb begin
    state_next      = state;
    cslot_next      = cslot;
    second_next     = second;
    bottom_next     = bottom;
    dsel_next       = dsel;
    oslot_next      = oslot;
    osecond_next    = osecond;
    ok_next         = ok;
    clr_bucket_next = clr_bucket;
    cmd             = '0;
    cmd.bottom      = bottom;
    cmd.second      = second;
    unique case (state)
      S_CLEAR: begin
        cmd.clr    = 1'b1;
        cslot_next = cslot + SW'(1);
        if (cslot == LAST_SLOT) begin
          cslot_next      = '0;
          clr_bucket_next = clr_bucket + BW'(1);
          if (clr_bucket == BW'(TABLE_BUCKETS - 1)) begin
            state_next = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load    = 1'b1;
          state_next  = S_HASH;
          cslot_next  = '0;
          second_next = 1'b0;
          bottom_next = 1'b0;
          dsel_next   = '0;
        end
      end
      S_HASH: begin
        if (stat.hash_done) begin
          state_next = (stat.mode == lhpt_pkg::MODE_DELETE) ? S_DELR : S_FREE;
        end
      end
      S_FREE: begin
        cmd.cap_pos = 1'b1;
        state_next  = S_FREEC;
      end
      S_FREEC: begin
        if (!stat.rd_valid) begin
          cmd.wr     = 1'b1;
          ok_next    = 1'b1;
          state_next = S_DONE;
        end else if (!cand_last) begin
          second_next = !second;
          if (second) cslot_next = cslot + SW'(1);
          state_next = S_FREE;
        end else begin
          // Level exhausted: bottom free search next, then eviction on top.
          cslot_next  = '0;
          second_next = 1'b0;
          bottom_next = !bottom;
          state_next  = bottom ? S_EVR : S_FREE;
        end
      end
      S_EVR: begin
        cmd.cap_pos = 1'b1;
        state_next  = S_EVC;
      end
      S_EVC: begin
        // Every slot is occupied at this point.
        cmd.cap_occ = 1'b1;
        state_next  = S_OHASH;
      end
      S_OHASH: begin
        cmd.hash_occ = 1'b1;
        oslot_next   = '0;
        osecond_next = 1'b0;
        state_next   = S_OR;
      end
      S_OR: begin
        cmd.use_occ = 1'b1;
        cmd.second  = osecond;
        if (stat.hash_done) state_next = S_OC;
      end
      S_OC: begin
        cmd.use_occ = 1'b1;
        cmd.second  = osecond;
        if (!stat.rd_valid) begin
          // The new entry takes the candidate's slot; the occupant moves next.
          cmd.wr     = 1'b1;
          state_next = S_OMOVE;
        end else if (!occ_last) begin
          osecond_next = !osecond;
          if (osecond) oslot_next = oslot + SW'(1);
          state_next = S_OR;
        end else if (!cand_last) begin
          second_next = !second;
          if (second) cslot_next = cslot + SW'(1);
          state_next = S_EVR;
        end else begin
          cslot_next  = '0;
          second_next = 1'b0;
          if (!bottom) begin
            bottom_next = 1'b1;
            state_next  = S_EVR;
          end else begin
            ok_next    = 1'b0;
            state_next = S_DONE;
          end
        end
      end
      S_OMOVE: begin
        cmd.use_occ = 1'b1;
        cmd.second  = osecond;
        cmd.wr      = 1'b1;
        cmd.wr_occ  = 1'b1;
        ok_next     = 1'b1;
        state_next  = S_DONE;
      end
      S_DELR: begin
        cmd.bottom  = dsel[1];
        cmd.second  = dsel[0];
        cmd.cap_pos = 1'b1;
        state_next  = S_DELC;
      end
      S_DELC: begin
        cmd.bottom = dsel[1];
        cmd.second = dsel[0];
        if (stat.rd_valid && stat.rd_match) begin
          cmd.wr       = 1'b1;
          cmd.wr_clear = 1'b1;
          ok_next      = 1'b1;
          state_next   = S_DONE;
        end else if (cslot != LAST_SLOT) begin
          cslot_next = cslot + SW'(1);
          state_next = S_DELR;
        end else begin
          cslot_next = '0;
          if (dsel == 2'd3) begin
            ok_next    = 1'b0;
            state_next = S_DONE;
          end else begin
            dsel_next  = dsel + 2'd1;
            state_next = S_DELR;
          end
        end
      end
      S_DONE: begin
        // Load the result once the previous one has left the register.
        if (!(out_valid && out_stall)) begin
          cmd.hold   = 1'b1;
          cmd.res_ok = ok;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/core/level_hash_page_table.sv
// Top level of the level-hashed page table.
//
//  channel | handshake            | payload
//  input   | valid, stall         | mode, virt_addr, entry_key, entry_value
//  result  | out_valid, out_stall | done_ok, level, bucket, out_value
//  config  | cfg_we               | cfg_data
//
// Reset starts a clearing pass over every slot of both tables with stall high.
// An item is accepted and hashed, its candidate slots are read and checked one at a time,
// and the result is loaded; a delete or a free insert ends at the first fitting slot.
// An insert with no free slot tries to move the occupant of each candidate slot in turn;
// it fails when no occupant on either level can move.
// Stall is high from acceptance until the result is loaded; a stalled result delays that load.
module level_hash_page_table #(
  parameter int TABLE_BUCKETS = 256,
  parameter int SLOTS_PER_BUCKET = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       valid,
  output logic                       stall,
  input  logic                       mode,
  input  logic [31:0]                virt_addr,
  input  logic [lhpt_pkg::KEY_W-1:0] entry_key,
  input  logic [lhpt_pkg::VAL_W-1:0] entry_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       done_ok,
  output logic                       level,
  output logic [7:0]                 bucket,
  output logic [31:0]                out_value,
  input  logic                       cfg_we,
  input  logic [31:0]                cfg_data
);

  localparam int SW = $clog2(SLOTS_PER_BUCKET > 1 ? SLOTS_PER_BUCKET : 2);

  logic [31:0] offset;
  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= 32'hC000_0000;
    end else if (cfg_we) begin
      offset <= cfg_data;
    end
  end

  lhpt_pkg::cmd_t  cmd;
  lhpt_pkg::stat_t stat;
  logic [SW-1:0]   slot;
  logic [$clog2(TABLE_BUCKETS)-1:0] clr_bucket;

  lhpt_ctrl #(.TABLE_BUCKETS(TABLE_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_ctrl (
    .clk(clk), .rst(rst), .in_valid(valid), .in_stall(stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd),
    .slot(slot), .clr_bucket(clr_bucket)
  );

  lhpt_datapath #(.TABLE_BUCKETS(TABLE_BUCKETS), .SLOTS_PER_BUCKET(SLOTS_PER_BUCKET)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .slot(slot), .clr_bucket(clr_bucket),
    .in_mode(mode), .in_addr(virt_addr), .in_key(entry_key), .in_value(entry_value),
    .offset(offset), .stat(stat), .res_ok(done_ok), .res_level(level),
    .res_bucket(bucket), .res_value(out_value)
  );

endmodule

>>> verif/level_hash_page_table_test.sv
// Self-checking testbench for the level-hashed page table, with its scoreboard class.
module level_hash_page_table_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBUCKETS = 256;
  localparam int NSLOTS = 4;
  localparam int HALF = NBUCKETS / 2;
  localparam int MODV = HALF - 1;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE = 600;

  typedef struct packed {
    logic        ok;
    logic        lvl;
    logic [7:0]  bkt;
    logic [31:0] val;
  } lookup_t;

  // Predicts each table operation and holds the results still owed by the block.
  class page_table_board;
    bit          slot_ok [2][NBUCKETS*NSLOTS];
    bit [19:0]   slot_key[2][NBUCKETS*NSLOTS];
    bit [31:0]   slot_val[2][NBUCKETS*NSLOTS];
    bit [31:0]   offset;
    lookup_t     owed[$];
    int          errors;

    function void clear();
      foreach (slot_ok[l, i]) slot_ok[l][i] = 0;
      offset = 32'hC000_0000;
      errors = 0;
    endfunction

    function void pair_of(bit [31:0] a, bit lvl, output int b1, output int b2);
      bit [31:0] m;
      m = a * 32'd7;
      b1 = a % MODV;
      b2 = m % MODV + HALF;
      if (lvl) begin
        b1 = b1 / 2;
        b2 = b2 / 2;
      end
    endfunction

    function bit has_free(bit [31:0] a, bit lvl);
      int b1, b2;
      pair_of(a, lvl, b1, b2);
      for (int s = 0; s < NSLOTS; s++) begin
        if (!slot_ok[lvl][b1*NSLOTS+s] || !slot_ok[lvl][b2*NSLOTS+s]) return 1;
      end
      return 0;
    endfunction

    function int put_free(bit [31:0] a, bit lvl, bit [19:0] k, bit [31:0] v);
      int b1, b2, b, i;
      pair_of(a, lvl, b1, b2);
      for (int s = 0; s < NSLOTS; s++) begin
        for (int j = 0; j < 2; j++) begin
          b = j ? b2 : b1;
          i = b * NSLOTS + s;
          if (!slot_ok[lvl][i]) begin
            slot_ok[lvl][i] = 1;
            slot_key[lvl][i] = k;
            slot_val[lvl][i] = v;
            return b;
          end
        end
      end
      return -1;
    endfunction

    // Displace one occupant that can still move within its own level.
    function int put_evict(bit [31:0] a, bit lvl, bit [19:0] k, bit [31:0] v);
      int b1, b2, b, i, r;
      bit [19:0] ok_key;
      bit [31:0] ok_val, oa;
      pair_of(a, lvl, b1, b2);
      for (int s = 0; s < NSLOTS; s++) begin
        for (int j = 0; j < 2; j++) begin
          b = j ? b2 : b1;
          i = b * NSLOTS + s;
          if (slot_ok[lvl][i]) begin
            ok_key = slot_key[lvl][i];
            ok_val = slot_val[lvl][i];
            oa = ok_val + offset;
            if (has_free(oa, lvl)) begin
              slot_key[lvl][i] = k;
              slot_val[lvl][i] = v;
              r = put_free(oa, lvl, ok_key, ok_val);
              return b;
            end
          end
        end
      end
      return -1;
    endfunction

    function void note_input(bit mode, bit [31:0] a, bit [19:0] k, bit [31:0] v);
      lookup_t e;
      int b, b1, b2, bs[4], i;
      bit lvl, hit;
      e = '0;
      if (mode == lhpt_pkg::MODE_INSERT) begin
        lvl = 0;
        b = put_free(a, 0, k, v);
        if (b < 0) begin lvl = 1; b = put_free(a, 1, k, v); end
        if (b < 0) begin lvl = 0; b = put_evict(a, 0, k, v); end
        if (b < 0) begin lvl = 1; b = put_evict(a, 1, k, v); end
        if (b >= 0) begin
          e.ok = 1;
          e.lvl = lvl;
          e.bkt = b[7:0];
          e.val = v;
        end
      end else begin
        pair_of(a, 0, b1, b2);
        bs[0] = b1; bs[1] = b2; bs[2] = b1 / 2; bs[3] = b2 / 2;
        hit = 0;
        for (int q = 0; q < 4 && !hit; q++) begin
          for (int s = 0; s < NSLOTS && !hit; s++) begin
            i = bs[q] * NSLOTS + s;
            if (slot_ok[q >= 2][i] && slot_key[q >= 2][i] == k) begin
              slot_ok[q >= 2][i] = 0;
              hit = 1;
              e.ok = 1;
              e.lvl = (q >= 2);
              e.bkt = bs[q][7:0];
              e.val = a - offset;
            end
          end
        end
      end
      owed.push_back(e);
    endfunction

    function void check_result(lookup_t got);
      lookup_t w;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result %h", $realtime, got);
        errors++;
        return;
      end
      w = owed.pop_front();
      if (got.ok !== w.ok) begin
        $display("%0t: done_ok expected %0d actual %0d", $realtime, w.ok, got.ok);
        errors++;
      end
      if (got.lvl !== w.lvl) begin
        $display("%0t: level expected %0d actual %0d", $realtime, w.lvl, got.lvl);
        errors++;
      end
      if (got.bkt !== w.bkt) begin
        $display("%0t: bucket expected %0d actual %0d", $realtime, w.bkt, got.bkt);
        errors++;
      end
      if (got.val !== w.val) begin
        $display("%0t: out_value expected %h actual %h", $realtime, w.val, got.val);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        valid = 0;
  logic        stall;
  logic        mode = 0;
  logic [31:0] virt_addr = 0;
  logic [19:0] entry_key = 0;
  logic [31:0] entry_value = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic        done_ok;
  logic        level;
  logic [7:0]  bucket;
  logic [31:0] out_value;
  logic        cfg_we = 0;
  logic [31:0] cfg_data = 0;

  page_table_board board = new();
  bit          quiet = 0;
  int          cycles = 0;
  int          rx_hold = 0;
  bit [31:0]   addr_pool[6];
  bit [19:0]   key_pool[$];

  level_hash_page_table #(.TABLE_BUCKETS(NBUCKETS), .SLOTS_PER_BUCKET(NSLOTS)) u_dut (
    .clk(clk), .rst(rst), .valid(valid), .stall(stall), .mode(mode),
    .virt_addr(virt_addr), .entry_key(entry_key), .entry_value(entry_value),
    .out_valid(out_valid), .out_stall(out_stall), .done_ok(done_ok), .level(level),
    .bucket(bucket), .out_value(out_value), .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts.
  always @(posedge clk) begin
    if (quiet || rst) begin
      out_stall <= 0;
      rx_hold <= 0;
    end else if (rx_hold > 0) begin
      rx_hold <= rx_hold - 1;
      out_stall <= 1;
    end else if ($urandom_range(0, 9) == 0) begin
      rx_hold <= $urandom_range(0, 13);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  // Record each input transfer and check each result transfer.
  always @(posedge clk) begin
    if (!rst && valid && !stall) board.note_input(mode, virt_addr, entry_key, entry_value);
    if (!rst && out_valid && !out_stall)
      board.check_result('{done_ok, level, bucket, out_value});
  end

  // Drive one input item and hold it until the block takes it.
  task automatic send_op(bit m, bit [31:0] a, bit [19:0] k, bit [31:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 14);
      valid <= 0;
      repeat (gap) @(posedge clk);
    end
    valid <= 1;
    mode <= m;
    virt_addr <= a;
    entry_key <= k;
    entry_value <= v;
    do @(posedge clk); while (stall);
    if (m == lhpt_pkg::MODE_INSERT) key_pool.push_back(k);
  endtask

  // Let the block drain, then write the offset register.
  task automatic set_offset(bit [31:0] v);
    valid <= 0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    @(posedge clk);
    board.offset = v;
    cfg_we <= 0;
  endtask

  // Mostly colliding addresses and keys so that buckets fill and evictions happen.
  task automatic random_op();
    bit [31:0] a, v;
    bit [19:0] k;
    a = ($urandom_range(0, 9) < 7) ? addr_pool[$urandom_range(0, 5)] : $urandom;
    if ($urandom_range(0, 99) < 35 && key_pool.size() > 0) begin
      k = ($urandom_range(0, 4) == 0) ? 20'($urandom) :
          key_pool[$urandom_range(0, key_pool.size() - 1)];
      send_op(lhpt_pkg::MODE_DELETE, a, k, $urandom);
    end else begin
      k = ($urandom_range(0, 3) == 0) ? 20'($urandom) : 20'($urandom_range(0, 31));
      v = ($urandom_range(0, 1) == 0) ?
          addr_pool[$urandom_range(0, 5)] - board.offset : $urandom;
      send_op(lhpt_pkg::MODE_INSERT, a, k, v);
    end
  endtask

  initial begin
    bit [31:0] x;
    bit [31:0] offsets[4];
    board.clear();
    repeat (6) @(posedge clk);
    rst <= 0;
    set_offset(32'hC000_0000);

    // Directed: field extremes, a miss, a full bucket set, duplicates.
    send_op(lhpt_pkg::MODE_INSERT, 32'h0, 20'h0, 32'h0);
    send_op(lhpt_pkg::MODE_INSERT, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF);
    send_op(lhpt_pkg::MODE_DELETE, 32'h0, 20'h0, 32'h0);
    send_op(lhpt_pkg::MODE_DELETE, 32'h0, 20'h0, 32'hFFFF_FFFF);
    x = $urandom;
    for (int i = 0; i < 17; i++) send_op(lhpt_pkg::MODE_INSERT, x, 20'(i), x - board.offset);
    send_op(lhpt_pkg::MODE_DELETE, x, 20'd3, 32'h0);
    send_op(lhpt_pkg::MODE_INSERT, x, 20'd5, x - board.offset);
    send_op(lhpt_pkg::MODE_DELETE, x, 20'd5, 32'h0);
    send_op(lhpt_pkg::MODE_DELETE, 32'hFFFF_FFFF, 20'hFFFFF, 32'h0);

    // Random phases under several offsets; the last runs without idling.
    offsets[0] = 32'h0;
    offsets[1] = 32'hFFFF_FFFF;
    offsets[2] = $urandom;
    offsets[3] = 32'hC000_0000;
    for (int p = 0; p < 4; p++) begin
      set_offset(offsets[p]);
      foreach (addr_pool[i]) addr_pool[i] = $urandom;
      if (p == 3) quiet = 1;
      for (int n = 0; n < 232; n++) random_op();
    end

    valid <= 0;
    @(posedge clk);
    while (board.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (board.owed.size() != 0) board.errors++;
    if (board.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/core/lhpt_pkg.sv
rtl/core/lhpt_ram.sv
rtl/core/lhpt_datapath.sv
rtl/core/lhpt_ctrl.sv
rtl/core/level_hash_page_table.sv
verif/level_hash_page_table_test.sv
